// ===== hw/rtl/sta_pkg.sv =====
// Package for the swap token arbiter: field widths, register codes, status codes, entry type.
package sta_pkg;

	localparam int PID_W       = 6;
	localparam int PID_SPAN    = 1 << PID_W;
	localparam int TIME_W      = 32;
	localparam int CFG_W       = 31;
	localparam int CFG_IDX_W   = 1;
	localparam int STATUS_W    = 3;
	localparam int PROCESS_SLOTS_DEF = 64;

	localparam logic [CFG_W-1:0] CHECK_INTERVAL_RST = CFG_W'(2000);
	localparam logic [CFG_W-1:0] HOLD_TIMEOUT_RST   = CFG_W'(300000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHECK_INTERVAL = 1'b0,
		CFG_HOLD_TIMEOUT   = 1'b1
	} cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_HOLDER_MARKED = 3'd0,
		ST_TOO_EARLY     = 3'd1,
		ST_BARRED        = 3'd2,
		ST_HOLDER_KEPT   = 3'd3,
		ST_TAKEN_IDLE    = 3'd4,
		ST_TAKEN_TIMEOUT = 3'd5,
		ST_EXIT_RELEASED = 3'd6,
		ST_EXIT_OTHER    = 3'd7
	} status_t;

	// per-slot entry: recent-fault mark and eligible time
	typedef struct packed {
		logic              recent;
		logic [TIME_W-1:0] elig;
	} entry_t;

endpackage

// ===== hw/rtl/swap_token_arbiter.sv =====
// Swap token arbiter: grants one protection token among process slots.
//
// Input channel (in_valid / in_stall) carries one word per event: kind
// (0 page fault, 1 exit), process_id and the wrapping tick count now. Output
// channel (out_valid / out_stall) returns one word per event: status and the
// token holder after the event. Config port (cfg_we, cfg_index, cfg_data)
// writes check_interval (index 0) and hold_timeout (index 1);
// write only while no event is in flight.
//
// Per-slot state sits in a two-read, one-write memory with a registered read.
// An event is accepted, both entries (requester and current holder) are read
// into the read stage at that edge, and once the output register is free or
// being taken the decision is written back and the result lands there. The
// read-modify-write of the memory means one event is in flight at a time;
// in_stall is held high while an event is in flight.
// A result waiting on a stalled receiver does not block acceptance; the next
// event then waits in the read stage until the output register empties.
// Reset clears the token to slot 0, all times and the per-slot valid bits
// (an invalid entry reads as zero), so no clearing pass is needed.
module swap_token_arbiter
	import sta_pkg::*;
#(
	parameter int PROCESS_SLOTS = PROCESS_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [PID_W-1:0]     process_id,
	input  logic [TIME_W-1:0]    now,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [STATUS_W-1:0]  status,
	output logic [PID_W-1:0]     holder,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// only the first PID_SPAN slots are reachable through a 6-bit id
	localparam int DEPTH = (PROCESS_SLOTS < PID_SPAN) ? PROCESS_SLOTS : PID_SPAN;
	localparam int IDX_W = $clog2(DEPTH);

	logic [IDX_W-1:0]  slot_map [PID_SPAN];
	entry_t            mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;

	logic [CFG_W-1:0]  interval_q, timeout_q;
	logic [IDX_W-1:0]  holder_q;
	logic [TIME_W-1:0] deadline_q, next_check_q;
	logic              busy_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [PID_W-1:0]  holder_out_q;

	logic              kind_s1;
	logic [IDX_W-1:0]  pid_s1;
	logic [TIME_W-1:0] now_s1;
	entry_t            rd_a_s1, rd_b_s1;
	logic              vld_a_s1, vld_b_s1;

	logic              accept, complete;
	logic [IDX_W-1:0]  pid_in;
	entry_t            req_e, old_e;
	logic              is_holder, after_check, barred, timed_out;
	logic [TIME_W-1:0] now_plus_int, now_plus_to;

	logic [IDX_W-1:0]  holder_d;
	logic [TIME_W-1:0] deadline_d, next_check_d;
	status_t           status_d;
	logic              mem_we, vld_clr;
	entry_t            wdata;

	// sign of a - b
	function automatic logic next_check_d_sub_msb(input logic [TIME_W-1:0] a,
	                                              input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

	// id to slot, reduced modulo the slot count
	genvar gi;
	generate
		for (gi = 0; gi < PID_SPAN; gi++) begin : g_map
			assign slot_map[gi] = IDX_W'(gi % PROCESS_SLOTS);
		end
	endgenerate

	assign pid_in   = slot_map[process_id];
	assign accept   = in_valid && !busy_q;
	assign complete = busy_q && (!out_valid_q || !out_stall);
	assign in_stall = busy_q;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign holder    = holder_out_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= CHECK_INTERVAL_RST;
			timeout_q  <= HOLD_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CHECK_INTERVAL: interval_q <= cfg_data;
				CFG_HOLD_TIMEOUT:   timeout_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// slot memory: read both entries at accept, write back at completion
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[holder_q] <= wdata;
		if (accept) begin
			rd_a_s1 <= mem[pid_in];
			rd_b_s1 <= mem[holder_q];
			kind_s1 <= kind;
			pid_s1  <= pid_in;
			now_s1  <= now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_s1 <= 1'b0;
			vld_b_s1 <= 1'b0;
		end else if (accept) begin
			vld_a_s1 <= vld_q[pid_in];
			vld_b_s1 <= vld_q[holder_q];
		end
	end

	// invalid entries read as zero
	assign req_e = vld_a_s1 ? rd_a_s1 : '0;
	assign old_e = vld_b_s1 ? rd_b_s1 : '0;

	assign is_holder    = (pid_s1 == holder_q);
	assign after_check  = next_check_d_sub_msb(next_check_q, now_s1);
	assign barred       = next_check_d_sub_msb(now_s1, req_e.elig);
	assign timed_out    = next_check_d_sub_msb(deadline_q, now_s1);
	assign now_plus_int = now_s1 + {1'b0, interval_q};
	assign now_plus_to  = now_s1 + {1'b0, timeout_q};

	always_comb begin
		holder_d     = holder_q;
		deadline_d   = deadline_q;
		next_check_d = next_check_q;
		status_d     = ST_HOLDER_KEPT;
		mem_we       = 1'b0;
		vld_clr      = 1'b0;
		wdata        = old_e;
		if (kind_s1) begin
			vld_clr = 1'b1;
			if (is_holder) begin
				holder_d     = '0;
				next_check_d = now_s1;
				status_d     = ST_EXIT_RELEASED;
			end else begin
				status_d = ST_EXIT_OTHER;
			end
		end else if (is_holder) begin
			mem_we       = 1'b1;
			wdata.recent = 1'b1;
			status_d     = ST_HOLDER_MARKED;
		end else if (!after_check) begin
			status_d = ST_TOO_EARLY;
		end else if (barred) begin
			status_d = ST_BARRED;
		end else begin
			next_check_d = now_plus_int;
			mem_we       = 1'b1;
			wdata.recent = 1'b0;
			if (!old_e.recent) begin
				wdata.elig = now_s1;
				deadline_d = now_plus_to;
				holder_d   = pid_s1;
				status_d   = ST_TAKEN_IDLE;
			end else if (timed_out) begin
				wdata.elig = now_plus_to;
				deadline_d = now_plus_to;
				holder_d   = pid_s1;
				status_d   = ST_TAKEN_TIMEOUT;
			end else begin
				status_d = ST_HOLDER_KEPT;
			end
		end
		if (!complete) begin
			mem_we  = 1'b0;
			vld_clr = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			holder_q     <= '0;
			deadline_q   <= '0;
			next_check_q <= '0;
			vld_q        <= '0;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (complete)
				busy_q <= 1'b0;

			if (complete)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (complete) begin
				holder_q     <= holder_d;
				deadline_q   <= deadline_d;
				next_check_q <= next_check_d;
			end
			if (mem_we)
				vld_q[holder_q] <= 1'b1;
			// exit returns the entry to its reset value
			if (vld_clr)
				vld_q[pid_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			status_q     <= status_d;
			holder_out_q <= PID_W'(holder_d);
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> busy_q)
		else $error("accepted word not held in read stage");

	a_complete_out: assert property (@(posedge clk) disable iff (!arst_n)
		complete |=> out_valid)
		else $error("completed word missing at output");

	a_holder_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!complete |=> $stable(holder_q) && $stable(next_check_q))
		else $error("token state changed outside completion");

	a_exit_release: assert property (@(posedge clk) disable iff (!arst_n)
		(complete && kind_s1 && is_holder) |=> (holder_q == '0))
		else $error("exit by holder did not release token");

endmodule

// ===== tb/swap_token_arbiter_checker.sv =====
// Checker for the swap token arbiter: watches both channels, predicts each word and compares.
`timescale 1ns / 100ps

module swap_token_arbiter_checker
	import sta_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 kind,
	input  logic [PID_W-1:0]     process_id,
	input  logic [TIME_W-1:0]    now,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [STATUS_W-1:0]  status,
	input  logic [PID_W-1:0]     holder,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   failures,
	output int                   outstanding
);

	typedef struct packed {
		status_t          st;
		logic [PID_W-1:0] slot;
	} outcome_t;

	// predicted arbiter state
	logic [CFG_W-1:0]  interval_cfg;
	logic [CFG_W-1:0]  timeout_cfg;
	logic [PID_W-1:0]  token_slot;
	logic [TIME_W-1:0] deadline;
	logic [TIME_W-1:0] next_check;
	logic              fault_mark [PID_SPAN];
	logic [TIME_W-1:0] eligible_at [PID_SPAN];

	outcome_t outcomes_due[$];
	outcome_t want;
	outcome_t grant;
	int       mismatches;
	int       slot_i;

	// a later than b by signed 32-bit difference
	function automatic logic is_later(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = b - a;
		return d[TIME_W-1];
	endfunction

	function automatic logic is_earlier(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

	task automatic arbitrate(input logic exit_ev, input logic [PID_W-1:0] pid,
			input logic [TIME_W-1:0] t, output outcome_t res);
		logic [PID_W-1:0] prev;
		logic             idle_holder;
		logic             timed_out;
		status_t          st;
		if (exit_ev) begin
			if (pid == token_slot) begin
				token_slot = '0;
				next_check = t;
				st = ST_EXIT_RELEASED;
			end else begin
				st = ST_EXIT_OTHER;
			end
			fault_mark[pid] = 1'b0;
			eligible_at[pid] = '0;
		end else if (pid == token_slot) begin
			fault_mark[pid] = 1'b1;
			st = ST_HOLDER_MARKED;
		end else if (!is_later(t, next_check)) begin
			st = ST_TOO_EARLY;
		end else if (is_earlier(t, eligible_at[pid])) begin
			st = ST_BARRED;
		end else begin
			prev = token_slot;
			next_check = t + {1'b0, interval_cfg};
			idle_holder = !fault_mark[prev];
			timed_out = fault_mark[prev] && is_later(t, deadline);
			fault_mark[prev] = 1'b0;
			if (idle_holder || timed_out) begin
				// a timed-out holder is barred for the hold timeout
				eligible_at[prev] = timed_out ? t + {1'b0, timeout_cfg} : t;
				deadline = t + {1'b0, timeout_cfg};
				token_slot = pid;
				st = timed_out ? ST_TAKEN_TIMEOUT : ST_TAKEN_IDLE;
			end else begin
				st = ST_HOLDER_KEPT;
			end
		end
		res.st = st;
		res.slot = token_slot;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_cfg = CHECK_INTERVAL_RST;
			timeout_cfg = HOLD_TIMEOUT_RST;
			token_slot = '0;
			deadline = '0;
			next_check = '0;
			for (slot_i = 0; slot_i < PID_SPAN; slot_i++) begin
				fault_mark[slot_i] = 1'b0;
				eligible_at[slot_i] = '0;
			end
			outcomes_due.delete();
			mismatches = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we === 1'b1) begin
				if (cfg_index == CFG_CHECK_INTERVAL)
					interval_cfg = cfg_data;
				else if (cfg_index == CFG_HOLD_TIMEOUT)
					timeout_cfg = cfg_data;
			end
			// result side first: a word leaving now belongs to an earlier event
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (outcomes_due.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result word: status %0d holder %0d",
							$time, status, holder);
					mismatches++;
				end else begin
					want = outcomes_due.pop_front();
					if (status !== want.st || holder !== want.slot) begin
						if (mismatches < 10)
							$display("%0t: mismatch: expected status %0d holder %0d, got status %0d holder %0d",
								$time, want.st, want.slot, status, holder);
						mismatches++;
					end
				end
			end
			if (in_valid === 1'b1 && in_stall === 1'b0) begin
				arbitrate(kind, process_id, now, grant);
				outcomes_due.push_back(grant);
			end
			failures <= mismatches;
			outstanding <= outcomes_due.size();
		end
	end

endmodule

// ===== tb/swap_token_arbiter_tb.sv =====
// Testbench top for the swap token arbiter: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module swap_token_arbiter_tb;
	import sta_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES = 6;
	localparam int PHASE_EVENTS = 90;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 kind;
	logic [PID_W-1:0]     process_id;
	logic [TIME_W-1:0]    now;
	logic                 out_valid;
	logic                 out_stall;
	logic [STATUS_W-1:0]  status;
	logic [PID_W-1:0]     holder;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   failures;
	int                   outstanding;
	int                   idle_cycles = 0;

	swap_token_arbiter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.process_id (process_id),
		.now        (now),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.holder     (holder),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	swap_token_arbiter_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.process_id  (process_id),
		.now         (now),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.holder      (holder),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// give up after a long stretch with no word moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_event(input logic k, input logic [PID_W-1:0] p,
			input logic [TIME_W-1:0] t);
		in_valid <= 1'b1;
		kind <= k;
		process_id <= p;
		now <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic program_phase(input logic [CFG_W-1:0] interval, input logic [CFG_W-1:0] timeout);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CHECK_INTERVAL;
		cfg_data <= interval;
		@(posedge clk);
		cfg_index <= CFG_HOLD_TIMEOUT;
		cfg_data <= timeout;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: a long hold-off first, then stretches of differing stall density
	initial begin : receiver
		int mode;
		int span;
		out_stall <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		out_stall <= 1'b1;
		repeat (70) @(posedge clk);
		forever begin
			mode = $urandom_range(3, 0);
			span = $urandom_range(80, 10);
			repeat (span) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(3, 0) == 0);
					2: out_stall <= ($urandom_range(3, 0) != 0);
					default: out_stall <= 1'b1;
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0]  interval_set [PHASES];
		logic [CFG_W-1:0]  timeout_set [PHASES];
		logic [TIME_W-1:0] tick;
		logic [TIME_W-1:0] delta;
		logic [PID_W-1:0]  pid;
		logic              exit_ev;
		longint            reach;
		int                burst_left;
		int                gap;
		int                pick;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= 1'b0;
		process_id <= '0;
		now <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CHECK_INTERVAL;
		cfg_data <= '0;

		interval_set = '{31'h7FFF_FFFF, 31'd1, 31'd0, 31'd50, 31'd2000, 31'd0};
		timeout_set = '{31'd0, 31'h7FFF_FFFF, 31'd100, 31'd5000, 31'd300000, 31'd0};
		interval_set[PHASES-1] = CFG_W'($urandom());
		timeout_set[PHASES-1] = CFG_W'($urandom());

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed walk under reset settings (interval 2000, timeout 300000)
		send_event(1'b0, 6'd0, 32'd0);          // idle owner marks itself
		send_event(1'b0, 6'd5, 32'd0);          // too early
		send_event(1'b0, 6'd5, 32'd1);          // takes from a marked, timed-out owner
		send_event(1'b0, 6'd5, 32'd2);
		send_event(1'b0, 6'd7, 32'd100);
		send_event(1'b0, 6'd7, 32'd2002);       // holder kept, mark cleared
		send_event(1'b0, 6'd7, 32'd4003);       // taken from unmarked holder
		send_event(1'b0, 6'd7, 32'd4004);
		send_event(1'b0, 6'd9, 32'd400000);     // timeout, slot 7 barred
		send_event(1'b0, 6'd7, 32'd500000);     // barred
		send_event(1'b1, 6'd9, 32'd500001);     // holder exits
		send_event(1'b1, 6'd12, 32'd500002);
		send_event(1'b1, 6'd0, 32'd500003);     // idle owner exits
		send_event(1'b0, 6'd63, 32'hFFFF_FFFF); // wraps to before the check
		send_event(1'b0, 6'd63, 32'h7FFF_FFFF);
		send_event(1'b0, 6'd63, 32'h8000_0000);
		send_event(1'b0, 6'd1, 32'hFFFF_FFFF);
		send_event(1'b0, 6'd42, 32'h5555_AAAA);
		send_event(1'b1, 6'd63, 32'd0);
		send_event(1'b0, 6'd21, 32'hAAAA_5555);

		tick = 32'd0;
		burst_left = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			program_phase(interval_set[ph], timeout_set[ph]);
			for (int n = 0; n < PHASE_EVENTS; n++) begin
				if (burst_left == 0) begin
					gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
					if (gap != 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst_left = $urandom_range(16, 1);
				end
				exit_ev = ($urandom_range(6, 0) == 0);
				pick = $urandom_range(9, 0);
				if (pick == 0)
					pid = '0;
				else if (pick <= 2)
					pid = PID_W'($urandom_range(PID_SPAN - 1, 0));
				else
					pid = PID_W'($urandom_range(4, 1));
				// time steps sized around the interval and the timeout
				pick = $urandom_range(9, 0);
				if (pick == 0) begin
					delta = '0;
				end else if (pick <= 3) begin
					delta = $urandom_range(16, 1);
				end else if (pick <= 6) begin
					reach = 2 * longint'(interval_set[ph]) + 2;
					delta = $urandom_range(32'(reach), 0);
				end else if (pick <= 8) begin
					reach = 2 * longint'(timeout_set[ph]) + 2;
					delta = $urandom_range(32'(reach), 0);
				end else begin
					delta = $urandom();
				end
				tick = tick + delta;
				send_event(exit_ev, pid, tick);
				burst_left--;
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
